@@ sv/bhq_pkg.sv @@
`default_nettype none

package bhq_pkg;

    // Field widths of the request and response words
    localparam int KEY_W   = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 10;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    // Default heap depth
    localparam int CAPACITY_DEF = 1024;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [OP_W-1:0]         t_op;
    typedef logic [STAT_W-1:0]       t_status;

    // Operation codes
    localparam t_op OP_INSERT   = 3'd0;
    localparam t_op OP_EXTRACT  = 3'd1;
    localparam t_op OP_PEEK     = 3'd2;
    localparam t_op OP_DECREASE = 3'd3;
    localparam t_op OP_DELETE   = 3'd4;

    // Status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_INDEX = 2'd3;

    // Largest key, returned on an empty extract or peek
    localparam t_key KEY_LARGEST = 32'sh7FFF_FFFF;

endpackage

`default_nettype wire

@@ sv/bhq_req_if.sv @@
`default_nettype none

interface bhq_req_if
    import bhq_pkg::*;
();
    logic  valid;
    logic  ready;
    t_op   operation;
    t_key  key;
    logic [POS_W-1:0] position;

    modport source (output valid, operation, key, position, input ready);
    modport sink   (input valid, operation, key, position, output ready);
endinterface

`default_nettype wire

@@ sv/bhq_rsp_if.sv @@
`default_nettype none

interface bhq_rsp_if
    import bhq_pkg::*;
();
    logic    valid;
    logic    ready;
    t_key    value;
    t_status status;
    logic [COUNT_W-1:0] count;

    modport source (output valid, value, status, count, input ready);
    modport sink   (input valid, value, status, count, output ready);
endinterface

`default_nettype wire

@@ sv/binary_min_heap_queue_top.sv @@
// Channel   Dir  Port    Word contents
// -------   ---  ------  ----------------------------------------------
// request   in   i_req   operation[2:0], key[31:0] signed, position[9:0]
// response  out  o_rsp   value[31:0] signed, status[1:0], count[10:0]
//
// One request at a time: peek reads the root; insert and decrease climb level by level;
// extract reads the root and the last entry, then descends level by level; delete reads
// the target, carries its slot to the root without compares, then proceeds as extract.
// At most one key read per cycle goes to the heap RAM; the response word is registered.
// Reset (synchronous, active low) empties the heap; the RAM needs no clear.
// A finished word waits in the output register while the next request is taken; a stalled
// response only holds the engine at its final step.
`default_nettype none

module binary_min_heap_queue_top
    import bhq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bhq_req_if.sink    i_req,
    bhq_rsp_if.source  o_rsp
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = AW + 2;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_PEEK     = 4'd3;
    localparam logic [3:0] S_EXT_ROOT = 4'd4;
    localparam logic [3:0] S_LAST     = 4'd5;
    localparam logic [3:0] S_DEL_VAL  = 4'd6;
    localparam logic [3:0] S_CARRY    = 4'd7;
    localparam logic [3:0] S_CARRY_WR = 4'd8;
    localparam logic [3:0] S_DN_L     = 4'd9;
    localparam logic [3:0] S_DN_R     = 4'd10;
    localparam logic [3:0] S_DN_CMP   = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    // Control state
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid;

    // Working payload: moving key, hole index, result, best child
    t_key          r_key, n_key;
    logic [AW-1:0] r_idx, n_idx;
    t_key          r_val, n_val;
    t_status       r_stat, n_stat;
    t_key          r_bkey, n_bkey;
    logic          r_bsel, n_bsel;
    logic          r_has_r, n_has_r;

    // Output register
    t_key               r_out_value;
    t_status            r_out_status;
    logic [COUNT_W-1:0] r_out_count;
    logic               out_load;

    // Heap RAM ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_key          mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_key          mem_rdata;

    // Index arithmetic
    logic [AW-1:0] par, par_par, last, nxt_idx;
    logic [XW-1:0] lc_x, rc_x, cnt_x, nlc_x;
    logic          pos_ok, take_r;

    bhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign par     = (r_idx - AW'(1)) >> 1;
    assign par_par = (par - AW'(1)) >> 1;
    assign last    = AW'(r_cnt - CW'(1));
    assign lc_x    = XW'({r_idx, 1'b1});
    assign rc_x    = lc_x + XW'(1);
    assign cnt_x   = XW'(r_cnt);
    assign pos_ok  = CMPW'(i_req.position) < CMPW'(r_cnt);

    // Right child wins only on a strictly smaller key than the best so far
    assign take_r  = r_has_r && (mem_rdata < r_bkey);
    assign nxt_idx = take_r ? AW'(rc_x) : AW'(lc_x);
    assign nlc_x   = XW'({nxt_idx, 1'b1});

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_key     = r_key;
        n_idx     = r_idx;
        n_val     = r_val;
        n_stat    = r_stat;
        n_bkey    = r_bkey;
        n_bsel    = r_bsel;
        n_has_r   = r_has_r;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_key;
        mem_raddr = '0;
        out_load  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_val   = '0;
                    n_stat  = ST_OK;
                    n_state = S_DONE;
                    unique case (i_req.operation) inside
                        OP_INSERT: begin
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_stat = ST_FULL;
                            end else begin
                                n_key   = i_req.key;
                                n_idx   = AW'(r_cnt);
                                n_cnt   = r_cnt + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        OP_EXTRACT, OP_PEEK: begin
                            if (r_cnt == '0) begin
                                n_val  = KEY_LARGEST;
                                n_stat = ST_EMPTY;
                            end else begin
                                mem_raddr = '0;
                                n_state   = (i_req.operation == OP_PEEK) ? S_PEEK
                                                                         : S_EXT_ROOT;
                            end
                        end
                        OP_DECREASE: begin
                            if (!pos_ok) begin
                                n_stat = ST_INDEX;
                            end else begin
                                n_key   = i_req.key;
                                n_idx   = AW'(i_req.position);
                                n_state = S_UP_RD;
                            end
                        end
                        OP_DELETE: begin
                            if (!pos_ok) begin
                                n_stat = ST_INDEX;
                            end else begin
                                mem_raddr = AW'(i_req.position);
                                n_idx     = AW'(i_req.position);
                                n_state   = S_DEL_VAL;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Sift up: hole at r_idx, moving key in r_key
            S_UP_RD: begin
                if (r_idx == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_raddr = par;
                    n_state   = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                mem_we = 1'b1;
                if (r_key < mem_rdata) begin
                    // pull the parent down, climb, and fetch the next parent
                    mem_wdata = mem_rdata;
                    n_idx     = par;
                    if (par == '0) begin
                        n_state = S_UP_RD;
                    end else begin
                        mem_raddr = par_par;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end

            S_PEEK: begin
                n_val   = mem_rdata;
                n_state = S_DONE;
            end

            S_EXT_ROOT: begin
                n_val     = mem_rdata;
                mem_raddr = last;
                n_cnt     = r_cnt - CW'(1);
                n_state   = S_LAST;
            end

            // Last entry becomes the key moving down from the root
            S_LAST: begin
                n_key   = mem_rdata;
                n_idx   = '0;
                n_state = S_DN_L;
            end

            S_DEL_VAL: begin
                n_val   = mem_rdata;
                n_state = S_CARRY;
            end

            // Carry the deleted slot to the root without compares
            S_CARRY: begin
                if (r_idx == '0) begin
                    mem_raddr = last;
                    n_cnt     = r_cnt - CW'(1);
                    n_state   = S_LAST;
                end else begin
                    mem_raddr = par;
                    n_state   = S_CARRY_WR;
                end
            end

            S_CARRY_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_idx     = par;
                if (par != '0) begin
                    mem_raddr = par_par;
                end else begin
                    // read of the last slot is issued from S_CARRY, behind this write
                    n_state = S_CARRY;
                end
            end

            // Sift down: hole at r_idx, moving key in r_key
            S_DN_L: begin
                if (lc_x < cnt_x) begin
                    mem_raddr = AW'(lc_x);
                    n_state   = S_DN_R;
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end
            end

            S_DN_R: begin
                if (mem_rdata < r_key) begin
                    n_bkey = mem_rdata;
                    n_bsel = 1'b1;
                end else begin
                    n_bkey = r_key;
                    n_bsel = 1'b0;
                end
                n_has_r = rc_x < cnt_x;
                if (rc_x < cnt_x) begin
                    mem_raddr = AW'(rc_x);
                end
                n_state = S_DN_CMP;
            end

            S_DN_CMP: begin
                mem_we = 1'b1;
                if (!take_r && !r_bsel) begin
                    n_state = S_DONE;
                end else begin
                    // lift the smaller child, descend, fetch its left child
                    mem_wdata = take_r ? mem_rdata : r_bkey;
                    n_idx     = nxt_idx;
                    if (nlc_x < cnt_x) begin
                        mem_raddr = AW'(nlc_x);
                        n_state   = S_DN_R;
                    end else begin
                        n_state = S_DN_L;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_stat  <= n_stat;
        r_bkey  <= n_bkey;
        r_bsel  <= n_bsel;
        r_has_r <= n_has_r;
        if (out_load) begin
            r_out_value  <= r_val;
            r_out_status <= r_stat;
            r_out_count  <= COUNT_W'(r_cnt);
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.value  = r_out_value;
    assign o_rsp.status = r_out_status;
    assign o_rsp.count  = r_out_count;

endmodule

`default_nettype wire

@@ sv/bhq_ram.sv @@
`default_nettype none

module bhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read sees the contents before a write at the same edge
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
